[sv/akima_spline_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Akima spline interpolator assertion macros
// Concurrent checks that compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef AKIMA_SPLINE_INTERPOLATOR_DEFINES_SVH
`define AKIMA_SPLINE_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ASI_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASI_ASSERT_HOLDS(label, clk, rst_n, ante, cons)
`define ASI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/asi_pkg.sv]
// ----------------------------------------------------------------------------
// Akima spline interpolator package
// Shared types and constants for the interpolator and its divider.
// ----------------------------------------------------------------------------
package asi_pkg;

    localparam int MAX_POINTS = 64;
    localparam int DIV_STEPS  = 64;
    localparam int CNT_MIN    = 3;

    localparam logic       OP_LOAD  = 1'b0;
    localparam logic       OP_QUERY = 1'b1;

    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_BELOW  = 2'd1;
    localparam logic [1:0] ST_ABOVE  = 2'd2;

    localparam logic [30:0] SLOPE_LIM = 31'h3FFF_FFFF;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } div_req_t;

endpackage

[sv/asi_div.sv]
// ----------------------------------------------------------------------------
// Akima spline interpolator divider
// Unsigned restoring divider, 64-bit dividend by 33-bit divisor, one
// quotient bit per cycle. Pulses done when the quotient is ready.
// ----------------------------------------------------------------------------
module asi_div
    import asi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [32:0] rem_reg;
    logic [63:0] quo_reg;
    logic [32:0] dvs_reg;

    logic [33:0] rem_sh;
    logic [34:0] diff;
    logic        ge;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[63]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        ge     = !diff[34];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 7'(DIV_STEPS - 1);
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvs_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[32:0] : rem_sh[32:0];
            quo_reg <= {quo_reg[62:0], ge};
            if (cnt_reg == 7'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 7'd1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/akima_spline_interpolator.sv]
// ----------------------------------------------------------------------------
// Akima spline interpolator
// Knot table in one synchronous memory; queries run on a sequencer that
// reads knots, builds five local slopes, two tangents and the Hermite value.
// Queries within the table use up to eight divisions on the shared 64-step
// divider and search the knots one by one. One item at a time.
// Reset: count 3, table contents undefined until loaded.
// ----------------------------------------------------------------------------
`include "akima_spline_interpolator_defines.svh"

module akima_spline_interpolator
    import asi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [6:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [5:0]         point_index,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] y_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] y_result,
    output logic [1:0]         status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int EW = AW + 2;
    localparam logic [1:0] LAST_STEP = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE, S_WAIT, S_FIRST, S_LAST, S_SRCH,
        S_SLP, S_SLP_A, S_SLP_B, S_SLP_DIV, S_EXTR, S_EXTL,
        S_TAN, S_TM1, S_TM2, S_TDIV, S_TWAIT,
        S_POS, S_POS_WAIT, S_COEF, S_MA, S_MB, S_MC, S_OUT
    } state_t;

    function automatic logic signed [31:0] sat_slope(input logic signed [33:0] v);
        if (v > $signed(34'(SLOPE_LIM)))
            return $signed({1'b0, SLOPE_LIM});
        else if (v < -$signed(34'(SLOPE_LIM)))
            return -$signed({1'b0, SLOPE_LIM});
        else
            return v[31:0];
    endfunction

    // knot memory: {x, y}
    logic [63:0]    knot_mem [MAX_POINTS];
    logic [63:0]    rd_data_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;

    state_t             state_reg;
    state_t             ret_reg;
    logic [6:0]         count_reg;
    logic [6:0]         cfg_clamped;
    logic [6:0]         n_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      k_reg;
    logic [AW-1:0]      i_reg;
    logic [2:0]         q_reg;
    logic               tsel_reg;
    logic [1:0]         step_reg;
    logic signed [31:0] xq_reg;
    logic signed [31:0] xa_reg;
    logic signed [31:0] ya_reg;
    logic signed [31:0] xi_reg;
    logic signed [31:0] xi1_reg;
    logic signed [31:0] yi_reg;
    logic signed [31:0] w_reg [5];
    logic signed [31:0] t0_reg;
    logic signed [31:0] t1_reg;
    logic signed [63:0] prod1_reg;
    logic signed [63:0] prod2_reg;
    logic               sneg_reg;
    logic               tneg_reg;
    logic               mneg_reg;
    logic signed [32:0] h_reg;
    logic [31:0]        s_reg;
    logic signed [34:0] c2_reg;
    logic signed [39:0] pv_reg;
    logic [55:0]        prod_hi_reg;
    logic [55:0]        prod_lo_reg;
    logic signed [31:0] res_y_reg;
    logic [1:0]         res_st_reg;
    logic               out_valid_reg;
    logic signed [31:0] y_result_reg;
    logic [1:0]         status_reg;
    div_req_t           div_req_reg;

    logic               div_done;
    logic [63:0]        div_quo;
    logic               div_start;
    logic               out_fire;
    logic               div_wait;

    logic signed [31:0] rd_x;
    logic signed [31:0] rd_y;
    logic signed [EW-1:0] e_idx;
    logic signed [EW-1:0] last_seg;
    logic               seg_live;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        abs_dx;
    logic [32:0]        abs_dy;
    logic [30:0]        slope_mag;
    logic signed [31:0] slope_val;
    logic [2:0]         r1;
    logic [2:0]         r2;
    logic [2:0]         l1;
    logic [2:0]         l2;
    logic signed [31:0] ext_r;
    logic signed [31:0] ext_l;
    logic [2:0]         tb;
    logic signed [31:0] ta0;
    logic signed [31:0] ta1;
    logic signed [31:0] ta2;
    logic signed [31:0] ta3;
    logic signed [32:0] da;
    logic signed [32:0] db;
    logic [31:0]        wa;
    logic [31:0]        wb;
    logic [31:0]        wsum;
    logic signed [32:0] msum;
    logic signed [32:0] mean33;
    logic signed [63:0] num;
    logic [63:0]        abs_num;
    logic signed [31:0] tdiv_val;
    logic signed [32:0] h;
    logic signed [32:0] pa;
    logic               h_le0;
    logic               pa_le0;
    logic signed [34:0] c2;
    logic signed [34:0] c3;
    logic [39:0]        u;
    logic [31:0]        f;
    logic [56:0]        tt;
    logic [56:0]        tsh;
    logic signed [63:0] r;
    logic               hpos;
    logic signed [63:0] yy;
    logic signed [31:0] yy_sat;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign y_result  = y_result_reg;
    assign status    = status_reg;

    assign out_fire = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign div_wait = (state_reg == S_SLP_DIV) || (state_reg == S_TWAIT)
                      || (state_reg == S_POS_WAIT);

    assign mem_we = in_valid && in_ready && (opcode == OP_LOAD)
                    && (32'(point_index) < MAX_POINTS);
    assign mem_wa = AW'(point_index);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            knot_mem[mem_wa] <= {x_value, y_value};
        rd_data_reg <= knot_mem[addr_reg];
    end

    always_comb
    begin
        if (cfg_wr_data < 7'(CNT_MIN))
            cfg_clamped = 7'(CNT_MIN);
        else if (32'(cfg_wr_data) > MAX_POINTS)
            cfg_clamped = 7'(MAX_POINTS);
        else
            cfg_clamped = cfg_wr_data;

        rd_x = rd_data_reg[63:32];
        rd_y = rd_data_reg[31:0];

        // segment index of window slot q: i - 2 + q
        e_idx    = $signed(EW'(i_reg) + EW'(q_reg) - EW'(2));
        last_seg = $signed(EW'(n_reg) - EW'(2));
        seg_live = (e_idx >= 0) && (e_idx <= last_seg);

        dx     = {rd_x[31], rd_x} - {xa_reg[31], xa_reg};
        dy     = {rd_y[31], rd_y} - {ya_reg[31], ya_reg};
        abs_dx = dx[32] ? 33'(-dx) : dx;
        abs_dy = dy[32] ? 33'(-dy) : dy;

        slope_mag = (div_quo > 64'(SLOPE_LIM)) ? SLOPE_LIM : div_quo[30:0];
        slope_val = sneg_reg ? -$signed({1'b0, slope_mag}) : $signed({1'b0, slope_mag});

        // linear extension beyond either end of the table
        r1 = (q_reg >= 3'd2) ? q_reg - 3'd1 : 3'd0;
        r2 = (q_reg >= 3'd2) ? q_reg - 3'd2 : 3'd0;
        l1 = (q_reg <= 3'd2) ? q_reg + 3'd1 : 3'd0;
        l2 = (q_reg <= 3'd2) ? q_reg + 3'd2 : 3'd0;
        ext_r = sat_slope((34'(w_reg[r1]) <<< 1) - 34'(w_reg[r2]));
        ext_l = sat_slope((34'(w_reg[l1]) <<< 1) - 34'(w_reg[l2]));

        tb   = {2'b00, tsel_reg};
        ta0  = w_reg[tb];
        ta1  = w_reg[tb + 3'd1];
        ta2  = w_reg[tb + 3'd2];
        ta3  = w_reg[tb + 3'd3];
        da   = 33'(ta3) - 33'(ta2);
        db   = 33'(ta1) - 33'(ta0);
        wa   = da[32] ? 32'(-da) : da[31:0];
        wb   = db[32] ? 32'(-db) : db[31:0];
        wsum = wa + wb;
        msum = 33'(ta2) + 33'(ta1);
        mean33 = (msum + (msum[32] ? 33'sd1 : 33'sd0)) >>> 1;

        num      = prod1_reg + prod2_reg;
        abs_num  = num[63] ? 64'(-num) : num;
        tdiv_val = tneg_reg ? -$signed({1'b0, div_quo[30:0]})
                            : $signed({1'b0, div_quo[30:0]});

        h      = {xi1_reg[31], xi1_reg} - {xi_reg[31], xi_reg};
        pa     = {xq_reg[31], xq_reg} - {xi_reg[31], xi_reg};
        h_le0  = h[32] || (h == 33'sd0);
        pa_le0 = pa[32] || (pa == 33'sd0);

        c2 = 35'(w_reg[2]) + 35'(w_reg[2]) + 35'(w_reg[2])
             - (35'(t0_reg) <<< 1) - 35'(t1_reg);
        c3 = 35'(t0_reg) + 35'(t1_reg) - (35'(w_reg[2]) <<< 1);

        u   = pv_reg[39] ? 40'(-pv_reg) : pv_reg;
        f   = (step_reg == LAST_STEP) ? h_reg[31:0] : s_reg;
        tt  = 57'(prod_hi_reg) + 57'(prod_lo_reg >> 16);
        tsh = (step_reg == LAST_STEP) ? tt : (tt >> 16);
        r   = mneg_reg ? -$signed(64'(tsh)) : $signed(64'(tsh));

        hpos = !h_reg[32] && (h_reg != 33'sd0);
        yy   = 64'(yi_reg) + (hpos ? r : 64'sd0);
        if (yy > 64'sh7FFF_FFFF)
            yy_sat = 32'sh7FFF_FFFF;
        else if (yy < -64'sh8000_0000)
            yy_sat = 32'sh8000_0000;
        else
            yy_sat = yy[31:0];

        // launch a division: slope with nonzero dx, weighted tangent, or interior position
        div_start = ((state_reg == S_SLP_B) && (dx != 33'sd0))
                    || (state_reg == S_TDIV)
                    || ((state_reg == S_POS) && !h_le0 && !pa_le0 && (pa < h));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            count_reg     <= 7'(CNT_MIN);
            n_reg         <= 7'(CNT_MIN);
            addr_reg      <= '0;
            k_reg         <= '0;
            i_reg         <= '0;
            q_reg         <= '0;
            tsel_reg      <= 1'b0;
            step_reg      <= '0;
            xq_reg        <= '0;
            xa_reg        <= '0;
            ya_reg        <= '0;
            xi_reg        <= '0;
            xi1_reg       <= '0;
            yi_reg        <= '0;
            for (int j = 0; j < 5; j++)
                w_reg[j] <= '0;
            t0_reg        <= '0;
            t1_reg        <= '0;
            prod1_reg     <= '0;
            prod2_reg     <= '0;
            sneg_reg      <= 1'b0;
            tneg_reg      <= 1'b0;
            mneg_reg      <= 1'b0;
            h_reg         <= '0;
            s_reg         <= '0;
            c2_reg        <= '0;
            pv_reg        <= '0;
            prod_hi_reg   <= '0;
            prod_lo_reg   <= '0;
            res_y_reg     <= '0;
            res_st_reg    <= ST_INSIDE;
            out_valid_reg <= 1'b0;
            y_result_reg  <= '0;
            status_reg    <= ST_INSIDE;
            div_req_reg   <= '0;
        end
        else
        begin
            div_req_reg.start <= div_start;
            if (cfg_wr_en)
                count_reg <= cfg_clamped;
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && (opcode == OP_QUERY))
                    begin
                        xq_reg    <= x_value;
                        n_reg     <= count_reg;
                        addr_reg  <= '0;
                        ret_reg   <= S_FIRST;
                        state_reg <= S_WAIT;
                    end
                end

                S_WAIT:
                begin
                    state_reg <= ret_reg;
                end

                S_FIRST:
                begin
                    if (xq_reg < rd_x)
                    begin
                        res_y_reg  <= rd_y;
                        res_st_reg <= ST_BELOW;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        addr_reg  <= AW'(n_reg - 7'd1);
                        ret_reg   <= S_LAST;
                        state_reg <= S_WAIT;
                    end
                end

                S_LAST:
                begin
                    if (xq_reg >= rd_x)
                    begin
                        res_y_reg  <= rd_y;
                        res_st_reg <= ST_ABOVE;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        k_reg     <= '0;
                        addr_reg  <= AW'(1);
                        ret_reg   <= S_SRCH;
                        state_reg <= S_WAIT;
                    end
                end

                // first k with query below x[k+1]
                S_SRCH:
                begin
                    if (xq_reg < rd_x)
                    begin
                        i_reg     <= k_reg;
                        q_reg     <= '0;
                        state_reg <= S_SLP;
                    end
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        addr_reg  <= k_reg + AW'(2);
                        ret_reg   <= S_SRCH;
                        state_reg <= S_WAIT;
                    end
                end

                S_SLP:
                begin
                    if (seg_live)
                    begin
                        addr_reg  <= AW'($unsigned(e_idx));
                        ret_reg   <= S_SLP_A;
                        state_reg <= S_WAIT;
                    end
                    else
                    begin
                        w_reg[q_reg] <= '0;
                        if (q_reg == 3'd4)
                        begin
                            q_reg     <= 3'd2;
                            state_reg <= S_EXTR;
                        end
                        else
                        begin
                            q_reg     <= q_reg + 3'd1;
                            state_reg <= S_SLP;
                        end
                    end
                end

                S_SLP_A:
                begin
                    xa_reg    <= rd_x;
                    ya_reg    <= rd_y;
                    addr_reg  <= addr_reg + AW'(1);
                    ret_reg   <= S_SLP_B;
                    state_reg <= S_WAIT;
                end

                S_SLP_B:
                begin
                    // the middle slot is the query's own interval
                    if (q_reg == 3'd2)
                    begin
                        xi_reg  <= xa_reg;
                        yi_reg  <= ya_reg;
                        xi1_reg <= rd_x;
                    end
                    if (dx == 33'sd0)
                    begin
                        w_reg[q_reg] <= '0;
                        if (q_reg == 3'd4)
                        begin
                            q_reg     <= 3'd2;
                            state_reg <= S_EXTR;
                        end
                        else
                        begin
                            q_reg     <= q_reg + 3'd1;
                            state_reg <= S_SLP;
                        end
                    end
                    else
                    begin
                        div_req_reg.dividend <= {15'd0, abs_dy, 16'd0};
                        div_req_reg.divisor  <= abs_dx;
                        sneg_reg             <= dx[32] ^ dy[32];
                        state_reg            <= S_SLP_DIV;
                    end
                end

                S_SLP_DIV:
                begin
                    if (div_done)
                    begin
                        w_reg[q_reg] <= slope_val;
                        if (q_reg == 3'd4)
                        begin
                            q_reg     <= 3'd2;
                            state_reg <= S_EXTR;
                        end
                        else
                        begin
                            q_reg     <= q_reg + 3'd1;
                            state_reg <= S_SLP;
                        end
                    end
                end

                // right end ascending, then left end descending
                S_EXTR:
                begin
                    if (e_idx > last_seg)
                        w_reg[q_reg] <= ext_r;
                    if (q_reg == 3'd4)
                    begin
                        q_reg     <= 3'd1;
                        state_reg <= S_EXTL;
                    end
                    else
                    begin
                        q_reg <= q_reg + 3'd1;
                    end
                end

                S_EXTL:
                begin
                    if (e_idx < 0)
                        w_reg[q_reg] <= ext_l;
                    if (q_reg == 3'd0)
                    begin
                        tsel_reg  <= 1'b0;
                        state_reg <= S_TAN;
                    end
                    else
                    begin
                        q_reg <= q_reg - 3'd1;
                    end
                end

                S_TAN:
                begin
                    if (wsum == 32'd0)
                    begin
                        if (!tsel_reg)
                        begin
                            t0_reg   <= mean33[31:0];
                            tsel_reg <= 1'b1;
                        end
                        else
                        begin
                            t1_reg    <= mean33[31:0];
                            state_reg <= S_POS;
                        end
                    end
                    else
                    begin
                        state_reg <= S_TM1;
                    end
                end

                S_TM1:
                begin
                    prod1_reg <= $signed(wa) * ta1;
                    state_reg <= S_TM2;
                end

                S_TM2:
                begin
                    prod2_reg <= $signed(wb) * ta2;
                    state_reg <= S_TDIV;
                end

                S_TDIV:
                begin
                    div_req_reg.dividend <= abs_num;
                    div_req_reg.divisor  <= {1'b0, wsum};
                    tneg_reg             <= num[63];
                    state_reg            <= S_TWAIT;
                end

                S_TWAIT:
                begin
                    if (div_done)
                    begin
                        if (!tsel_reg)
                        begin
                            t0_reg    <= tdiv_val;
                            tsel_reg  <= 1'b1;
                            state_reg <= S_TAN;
                        end
                        else
                        begin
                            t1_reg    <= tdiv_val;
                            state_reg <= S_POS;
                        end
                    end
                end

                S_POS:
                begin
                    h_reg <= h;
                    if (h_le0 || pa_le0)
                    begin
                        s_reg     <= '0;
                        state_reg <= S_COEF;
                    end
                    else if (pa >= h)
                    begin
                        s_reg     <= '1;
                        state_reg <= S_COEF;
                    end
                    else
                    begin
                        div_req_reg.dividend <= {pa[31:0], 32'd0};
                        div_req_reg.divisor  <= h;
                        state_reg            <= S_POS_WAIT;
                    end
                end

                S_POS_WAIT:
                begin
                    if (div_done)
                    begin
                        s_reg     <= div_quo[31:0];
                        state_reg <= S_COEF;
                    end
                end

                S_COEF:
                begin
                    c2_reg    <= c2;
                    pv_reg    <= 40'(c3);
                    step_reg  <= '0;
                    state_reg <= S_MA;
                end

                S_MA:
                begin
                    prod_hi_reg <= 56'(u) * 56'(f[31:16]);
                    mneg_reg    <= pv_reg[39];
                    state_reg   <= S_MB;
                end

                S_MB:
                begin
                    prod_lo_reg <= 56'(u) * 56'(f[15:0]);
                    state_reg   <= S_MC;
                end

                // Horner steps, then scale by the interval width
                S_MC:
                begin
                    unique case (step_reg)
                        2'd0:
                        begin
                            pv_reg    <= 40'(r + 64'(c2_reg));
                            step_reg  <= 2'd1;
                            state_reg <= S_MA;
                        end
                        2'd1:
                        begin
                            pv_reg    <= 40'(r + 64'(t0_reg));
                            step_reg  <= 2'd2;
                            state_reg <= S_MA;
                        end
                        2'd2:
                        begin
                            pv_reg    <= 40'(r);
                            step_reg  <= LAST_STEP;
                            state_reg <= S_MA;
                        end
                        default:
                        begin
                            res_y_reg  <= yy_sat;
                            res_st_reg <= ST_INSIDE;
                            state_reg  <= S_OUT;
                        end
                    endcase
                end

                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        y_result_reg  <= res_y_reg;
                        status_reg    <= res_st_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    asi_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    `ASI_ASSERT_NEXT(a_out_load, clk, rst_n, out_fire, out_valid_reg && state_reg == S_IDLE)
    `ASI_ASSERT_HOLDS(a_div_expected, clk, rst_n, div_done, div_wait)
    `ASI_ASSERT_HOLDS(a_count_range, clk, rst_n, 1'b1, count_reg >= 7'(CNT_MIN) && 32'(count_reg) <= MAX_POINTS)

endmodule
